[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. All checks are sampled on the rising
// edge of clk; BSL_ASSERT checks are switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled during reset.
`define BSL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define BSL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/bsl_pkg.sv]
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants of the button short/long press classifier.
// ----------------------------------------------------------------------------
package bsl_pkg;

	// Fixed field widths.
	localparam int PIN_W     = 4;
	localparam int CFG_W     = 10;
	localparam int CNT_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register reset values.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 10'd5;
	localparam logic [CFG_W-1:0] LONG_RST     = 10'd100;

	// Default lane count.
	localparam int NUM_BUTTONS_DEF = 4;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_LONG     = 1'b1
	} cfg_idx_t;

	// Per-button press state.
	typedef enum logic [1:0] {
		PS_RELEASED = 2'd0,
		PS_PRESSED  = 2'd1,
		PS_LONG     = 2'd2
	} press_state_t;

	// What one lane found on one tick.
	typedef struct packed {
		logic short_hit;
		logic long_hit;
	} lane_evt_t;

endpackage

[hdl/bsl_if.sv]
// ----------------------------------------------------------------------------
// bsl_tick_if / bsl_press_if
// Valid/ready channels for scan ticks and press results.
// ----------------------------------------------------------------------------
interface bsl_tick_if;
	logic                          valid;
	logic                          ready;
	logic [bsl_pkg::PIN_W-1:0]     pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bsl_press_if;
	logic                          valid;
	logic                          ready;
	logic [bsl_pkg::PIN_W-1:0]     short_press_mask;
	logic [bsl_pkg::PIN_W-1:0]     long_press_mask;

	modport source (output valid, output short_press_mask, output long_press_mask,
		input ready);
	modport sink   (input valid, input short_press_mask, input long_press_mask,
		output ready);
endinterface

[hdl/button_short_long_press_classifier_unit.sv]
// ----------------------------------------------------------------------------
// button_short_long_press_classifier_unit
// Classifies button presses as short or long, one scan tick per beat.
// ----------------------------------------------------------------------------
// Usage: every beat on the tick channel carries the active-low pin levels of
// the buttons for one scan tick. For every tick beat exactly one beat leaves
// on the press channel, with a short-press mask and a long-press mask.
// A tick's result is registered: it shows in the cycle after the tick is
// accepted. Throughput is one tick per cycle while the receiver takes each
// beat. Each button has its own lane whose state and counter update on
// every accepted tick; lanes run in parallel into a merging output register.
// The tick channel stays ready while the output register is empty or is
// being emptied in the same cycle, so when the receiver stalls the block
// holds one result and then stops taking ticks until that beat is taken.
// Reset (arst_n low) puts every button in the released state with a zero
// counter, empties the output register and loads the threshold registers
// with 5 (debounce) and 100 (long press). Thresholds are written through
// cfg_we/cfg_index/cfg_wdata while no tick is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_short_long_press_classifier_unit #(
	parameter int NUM_BUTTONS = bsl_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsl_pkg::CFG_W-1:0]           cfg_wdata,
	bsl_tick_if.sink                            tick,
	bsl_press_if.source                         press
);

	// Only the pins that exist on the tick field can ever change a mask bit.
	localparam int NUM_LANES = (NUM_BUTTONS < bsl_pkg::PIN_W) ? NUM_BUTTONS
		: bsl_pkg::PIN_W;

	logic [bsl_pkg::CFG_W-1:0] debounce_q;
	logic [bsl_pkg::CFG_W-1:0] long_q;
	logic                      tick_fire;
	logic                      out_valid;
	bsl_pkg::lane_evt_t        evt [NUM_LANES];

	// Threshold registers. The user must write them only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bsl_pkg::DEBOUNCE_RST;
			long_q     <= bsl_pkg::LONG_RST;
		end else if (cfg_we) begin
			case (bsl_pkg::cfg_idx_t'(cfg_index))
				bsl_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata;
				bsl_pkg::CFG_LONG:     long_q     <= cfg_wdata;
				default: begin
					debounce_q <= debounce_q;
				end
			endcase
		end
	end

	// The output register can take a new result when it is empty or its
	// current beat leaves in this same cycle.
	assign tick.ready = !out_valid || press.ready;
	assign tick_fire  = tick.valid && tick.ready;

	// One lane per button; a low pin means the button is held.
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		bsl_lane u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.fire             (tick_fire),
			.down             (!tick.pin_levels[i]),
			.debounce_ticks   (debounce_q),
			.long_press_ticks (long_q),
			.evt              (evt[i])
		);
	end

	bsl_merge #(
		.NUM_LANES (NUM_LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (tick_fire),
		.evt        (evt),
		.out_ready  (press.ready),
		.out_valid  (out_valid),
		.short_mask (press.short_press_mask),
		.long_mask  (press.long_press_mask)
	);

	assign press.valid = out_valid;

	// A short press comes from a release and a long press from a held pin,
	// so no button can report both in one result.
	`BSL_ASSERT(a_no_dual_event, press.valid |-> ((press.short_press_mask & press.long_press_mask) == '0), "button reported short and long press in one beat")
	// Every accepted tick produces a result in the next cycle.
	`BSL_ASSERT(a_tick_gives_result, tick_fire |=> press.valid, "accepted tick produced no result")
	// An empty output register never blocks the tick channel.
	`BSL_ASSERT_ALWAYS(a_ready_when_empty, !press.valid |-> tick.ready, "tick channel stalled with empty output register")

endmodule

[hdl/bsl_lane.sv]
// ----------------------------------------------------------------------------
// bsl_lane
// One button: press state machine and saturating held-tick counter.
// ----------------------------------------------------------------------------
module bsl_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  logic                             down,
	input  logic [bsl_pkg::CFG_W-1:0]        debounce_ticks,
	input  logic [bsl_pkg::CFG_W-1:0]        long_press_ticks,
	output bsl_pkg::lane_evt_t               evt
);

	bsl_pkg::press_state_t            state_q, state_d;
	logic [bsl_pkg::CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsl_pkg::PS_RELEASED;
			cnt_q   <= '0;
		end else if (fire) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign cnt_inc = (cnt_q == bsl_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		evt     = '0;
		if (down) begin
			case (state_q)
				bsl_pkg::PS_RELEASED: begin
					cnt_d   = '0;
					state_d = bsl_pkg::PS_PRESSED;
				end
				bsl_pkg::PS_PRESSED: begin
					cnt_d = cnt_inc;
					if (cnt_inc > {1'b0, long_press_ticks}) begin
						state_d      = bsl_pkg::PS_LONG;
						evt.long_hit = 1'b1;
					end
				end
				default: begin
					// Long-pressed (and the unused code) simply hold.
					state_d = state_q;
				end
			endcase
		end else begin
			if (state_q == bsl_pkg::PS_PRESSED && cnt_q > {1'b0, debounce_ticks})
				evt.short_hit = 1'b1;
			state_d = bsl_pkg::PS_RELEASED;
		end
	end

endmodule

[hdl/bsl_merge.sv]
// ----------------------------------------------------------------------------
// bsl_merge
// Gathers the lane events into the two masks and holds them in the output
// register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module bsl_merge #(
	parameter int NUM_LANES = bsl_pkg::NUM_BUTTONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  bsl_pkg::lane_evt_t               evt [NUM_LANES],
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [bsl_pkg::PIN_W-1:0]        short_mask,
	output logic [bsl_pkg::PIN_W-1:0]        long_mask
);

	logic [bsl_pkg::PIN_W-1:0] short_d, long_d;
	logic                      valid_q;
	logic [bsl_pkg::PIN_W-1:0] short_q, long_q;

	for (genvar i = 0; i < bsl_pkg::PIN_W; i++) begin : g_bit
		if (i < NUM_LANES) begin : g_lane
			assign short_d[i] = evt[i].short_hit;
			assign long_d[i]  = evt[i].long_hit;
		end else begin : g_none
			assign short_d[i] = 1'b0;
			assign long_d[i]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (fire)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			short_q <= short_d;
			long_q  <= long_d;
		end
	end

	assign out_valid  = valid_q;
	assign short_mask = short_q;
	assign long_mask  = long_q;

endmodule
